// ----- rtl/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths and pipeline types shared by the triangle face normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

   localparam int COORD_BITS       = 16;
   localparam int NORMAL_FRAC_BITS = 14;

   // Edge, product, cross product, magnitude, square and sum widths, all exact.
   localparam int EDGE_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * EDGE_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_BITS   = PROD_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int SUM_BITS   = SQ_BITS + 2;

   // Quotient magnitude, output width and residual width of the search.
   localparam int QUOT_BITS = NORMAL_FRAC_BITS + 1;
   localparam int OUT_BITS  = NORMAL_FRAC_BITS + 2;
   localparam int RES_BITS  = SUM_BITS + 2 * NORMAL_FRAC_BITS + 6;
   localparam int IDX_BITS  = $clog2(QUOT_BITS);
   localparam int T_SHIFT   = 2 * NORMAL_FRAC_BITS + 2;

   // One normal component while its quotient is being decided.
   typedef struct packed {
      logic signed [RES_BITS-1:0] d;
      logic signed [RES_BITS-1:0] p;
      logic [QUOT_BITS-1:0]       q;
      logic                       neg;
   } lane_type;

   // Everything a cell hands to its neighbor.
   typedef struct packed {
      logic [SUM_BITS-1:0] s;
      logic                degen;
      lane_type [2:0]      lane;
   } cell_type;

endpackage

`default_nettype wire

// ----- rtl/tfn_front.sv -----
// ----------------------------------------------------------------------------
// tfn_front
// Edges, cross product, squared length and initial search residuals.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   output logic                                       in_ready,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v0_x,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v0_y,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v0_z,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v1_x,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v1_y,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v1_z,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v2_x,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v2_y,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v2_z,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output tfn_pkg::cell_type                          out_data
);

   localparam int NSTAGE = 6;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] load;

   logic signed [tfn_pkg::EDGE_BITS-1:0]  a_ff [3];
   logic signed [tfn_pkg::EDGE_BITS-1:0]  b_ff [3];
   logic signed [tfn_pkg::PROD_BITS-1:0]  prod_ff [6];
   logic signed [tfn_pkg::PROD_BITS-1:0]  prod_in [6];
   logic [tfn_pkg::MAG_BITS-1:0]          mag_ff [3];
   logic [tfn_pkg::MAG_BITS-1:0]          mag_in [3];
   logic [2:0]                            negc_ff;
   logic [2:0]                            negd_ff;
   logic [2:0]                            nege_ff;
   logic [2:0]                            negc_in;
   logic [tfn_pkg::SQ_BITS-1:0]           sqd_ff [3];
   logic [tfn_pkg::SQ_BITS-1:0]           sqe_ff [3];
   logic [tfn_pkg::SUM_BITS-1:0]          s_ff;
   logic [tfn_pkg::SUM_BITS-1:0]          s_in;
   logic signed [tfn_pkg::CROSS_BITS-1:0] cross_val [3];
   tfn_pkg::cell_type                     out_ff;
   tfn_pkg::cell_type                     out_in;

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      load[NSTAGE-1] = !valid_ff[NSTAGE-1] || out_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[NSTAGE-1];
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (load[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i < NSTAGE; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // Cross product terms: c = a x b.
   always_comb begin
      prod_in[0] = a_ff[1] * b_ff[2];
      prod_in[1] = a_ff[2] * b_ff[1];
      prod_in[2] = a_ff[2] * b_ff[0];
      prod_in[3] = a_ff[0] * b_ff[2];
      prod_in[4] = a_ff[0] * b_ff[1];
      prod_in[5] = a_ff[1] * b_ff[0];
      for (int k = 0; k < 3; k++) begin
         cross_val[k] = tfn_pkg::CROSS_BITS'(prod_ff[2*k]) -
                        tfn_pkg::CROSS_BITS'(prod_ff[2*k+1]);
         negc_in[k]   = cross_val[k][tfn_pkg::CROSS_BITS-1];
         mag_in[k]    = negc_in[k] ? tfn_pkg::MAG_BITS'(-cross_val[k])
                                   : tfn_pkg::MAG_BITS'(cross_val[k]);
      end
      s_in = tfn_pkg::SUM_BITS'(sqd_ff[0]) + tfn_pkg::SUM_BITS'(sqd_ff[1]) +
             tfn_pkg::SUM_BITS'(sqd_ff[2]);
   end

   // Initial residual T - S and running product -S for each component.
   always_comb begin
      out_in.s     = s_ff;
      out_in.degen = (s_ff == '0);
      for (int k = 0; k < 3; k++) begin
         out_in.lane[k].d   = (tfn_pkg::RES_BITS'(sqe_ff[k]) << tfn_pkg::T_SHIFT) -
                              tfn_pkg::RES_BITS'(s_ff);
         out_in.lane[k].p   = -tfn_pkg::RES_BITS'(s_ff);
         out_in.lane[k].q   = '0;
         out_in.lane[k].neg = nege_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         a_ff[0] <= tfn_pkg::EDGE_BITS'(v2_x) - tfn_pkg::EDGE_BITS'(v0_x);
         a_ff[1] <= tfn_pkg::EDGE_BITS'(v2_y) - tfn_pkg::EDGE_BITS'(v0_y);
         a_ff[2] <= tfn_pkg::EDGE_BITS'(v2_z) - tfn_pkg::EDGE_BITS'(v0_z);
         b_ff[0] <= tfn_pkg::EDGE_BITS'(v1_x) - tfn_pkg::EDGE_BITS'(v0_x);
         b_ff[1] <= tfn_pkg::EDGE_BITS'(v1_y) - tfn_pkg::EDGE_BITS'(v0_y);
         b_ff[2] <= tfn_pkg::EDGE_BITS'(v1_z) - tfn_pkg::EDGE_BITS'(v0_z);
      end
      if (load[1]) begin
         prod_ff <= prod_in;
      end
      if (load[2]) begin
         mag_ff  <= mag_in;
         negc_ff <= negc_in;
      end
      if (load[3]) begin
         for (int k = 0; k < 3; k++) begin
            sqd_ff[k] <= mag_ff[k] * mag_ff[k];
         end
         negd_ff <= negc_ff;
      end
      if (load[4]) begin
         s_ff    <= s_in;
         sqe_ff  <= sqd_ff;
         nege_ff <= negd_ff;
      end
      if (load[5]) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tfn_cell.sv -----
// ----------------------------------------------------------------------------
// tfn_cell
// Decides one quotient bit of all three normal components.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [tfn_pkg::IDX_BITS-1:0] bit_idx,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire tfn_pkg::cell_type            in_data,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output tfn_pkg::cell_type                 out_data
);

   logic                               valid_ff;
   tfn_pkg::cell_type                  data_ff;
   tfn_pkg::cell_type                  data_in;
   logic signed [tfn_pkg::RES_BITS-1:0] sj;
   logic signed [tfn_pkg::RES_BITS-1:0] term [3];
   logic [2:0]                          fit;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Trial bit b: (2(q+b)-1)^2 S grows by 4b(S(2q-1) + bS).
   always_comb begin
      sj      = tfn_pkg::RES_BITS'(in_data.s) << bit_idx;
      data_in = in_data;
      for (int k = 0; k < 3; k++) begin
         term[k] = ((in_data.lane[k].p + sj) << bit_idx) << 2;
         fit[k]  = ($signed(in_data.lane[k].d) >= term[k]);
         if (fit[k]) begin
            data_in.lane[k].d = in_data.lane[k].d - term[k];
            data_in.lane[k].p = in_data.lane[k].p + (sj << 1);
            data_in.lane[k].q = in_data.lane[k].q |
                                (tfn_pkg::QUOT_BITS'(1) << bit_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/triangle_face_normal.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle in Q1.14, rounded to nearest.
// ----------------------------------------------------------------------------
// The block accepts one triangle per clock while not backed up by a stall and
// answers each with one response: six front stages form the edges, the cross
// product, its squared length and the starting residuals, then 15 identical
// cells decide one bit of every normal component per cycle, most significant
// bit first. A stalled response holds only the stages behind it; empty stages
// keep filling. A zero cross product gives a zero normal with degenerate set.
`default_nettype none

module triangle_face_normal (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] req_v0_x,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] req_v0_y,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] req_v0_z,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] req_v1_x,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] req_v1_y,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] req_v1_z,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] req_v2_x,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] req_v2_y,
   input  wire logic signed [tfn_pkg::COORD_BITS-1:0] req_v2_z,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [tfn_pkg::OUT_BITS-1:0]        rsp_normal_x,
   output logic signed [tfn_pkg::OUT_BITS-1:0]        rsp_normal_y,
   output logic signed [tfn_pkg::OUT_BITS-1:0]        rsp_normal_z,
   output logic                                       rsp_degenerate
);

   localparam int NCELL = tfn_pkg::QUOT_BITS;

   logic                    req_ready;
   logic [NCELL:0]          valid;
   logic [NCELL:0]          ready;
   tfn_pkg::cell_type       data [NCELL+1];
   logic signed [tfn_pkg::OUT_BITS-1:0] normal [3];

   assign req_stall = !req_ready;

   tfn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .v0_x      (req_v0_x),
      .v0_y      (req_v0_y),
      .v0_z      (req_v0_z),
      .v1_x      (req_v1_x),
      .v1_y      (req_v1_y),
      .v1_z      (req_v1_z),
      .v2_x      (req_v2_x),
      .v2_y      (req_v2_y),
      .v2_z      (req_v2_z),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_data  (data[0])
   );

   // Cell k decides quotient bit NCELL-1-k.
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      tfn_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .bit_idx   (tfn_pkg::IDX_BITS'(NCELL - 1 - k)),
         .in_valid  (valid[k]),
         .in_ready  (ready[k]),
         .in_data   (data[k]),
         .out_valid (valid[k+1]),
         .out_ready (ready[k+1]),
         .out_data  (data[k+1])
      );
   end

   assign ready[NCELL] = !rsp_stall;
   assign rsp_valid    = valid[NCELL];

   // Apply signs after rounding; a degenerate triangle gives zero.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (data[NCELL].degen) begin
            normal[k] = '0;
         end else if (data[NCELL].lane[k].neg) begin
            normal[k] = -tfn_pkg::OUT_BITS'(data[NCELL].lane[k].q);
         end else begin
            normal[k] = tfn_pkg::OUT_BITS'(data[NCELL].lane[k].q);
         end
      end
   end

   assign rsp_normal_x   = normal[0];
   assign rsp_normal_y   = normal[1];
   assign rsp_normal_z   = normal[2];
   assign rsp_degenerate = data[NCELL].degen;

endmodule

`default_nettype wire

// ----- rtl/tfn_checker.sv -----
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks of the triangle face normal block.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic signed [tfn_pkg::OUT_BITS-1:0]   rsp_normal_x,
   input wire logic signed [tfn_pkg::OUT_BITS-1:0]   rsp_normal_y,
   input wire logic signed [tfn_pkg::OUT_BITS-1:0]   rsp_normal_z,
   input wire logic                                  rsp_degenerate
);

   localparam logic signed [tfn_pkg::OUT_BITS-1:0] ONE =
      tfn_pkg::OUT_BITS'(1) << tfn_pkg::NORMAL_FRAC_BITS;

   // A stalled response stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Nothing comes out in the cycle after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A degenerate response carries a zero normal.
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate response with nonzero normal");

   // A unit normal never leaves the range of one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_normal_x <= ONE && rsp_normal_x >= -ONE &&
         rsp_normal_y <= ONE && rsp_normal_y >= -ONE &&
         rsp_normal_z <= ONE && rsp_normal_z >= -ONE)
      else $error("normal component out of range");

   // A real triangle cannot give a zero normal.
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0)
      else $error("zero normal without degenerate flag");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_normal_x   (rsp_normal_x),
   .rsp_normal_y   (rsp_normal_y),
   .rsp_normal_z   (rsp_normal_z),
   .rsp_degenerate (rsp_degenerate)
);

`default_nettype wire
